@@ sv/rbs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbs_pkg
// Types, constants and arithmetic helpers of the ray/box slab test.
// ---------------------------------------------------------------------------
package rbs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QW        = 33;               // quotient bits produced
   localparam int NUM_W     = QW + FRAC_BITS;   // scaled numerator magnitude
   localparam int AXES      = 3;
   localparam int LANES     = 2 * AXES;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [31:0]   INT_MIN  = 32'h8000_0000;
   localparam logic [31:0]   INT_MAX  = 32'h7FFF_FFFF;
   localparam logic [15:0]   EPS_RST  = 16'd1;
   localparam logic [QW-1:0] NEG_LIM  = {{(QW - 32){1'b0}}, 32'h8000_0000};

   typedef struct packed {
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] entry_distance;
   } rsp_type;

   // one divider lane: partial remainder, unconsumed numerator bits, quotient
   typedef struct packed {
      logic [31:0]   rem;
      logic [QW-1:0] low;
      logic [QW-1:0] quo;
      logic [31:0]   dvs;
      logic          neg;
      logic          ovf;
   } lane_type;

   // classified item; lane 2a is the lower bound of axis a, 2a+1 the upper
   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic [AXES-1:0]      par;
      logic                 pmiss;
   } cls_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

   function automatic lane_type lane_prep(input logic [31:0] bound,
                                          input logic [31:0] org,
                                          input logic [31:0] dir);
      logic [32:0]          diff;
      logic [32:0]          dmag;
      logic [NUM_W-1:0]     num;
      logic [FRAC_BITS-1:0] high;
      lane_type             r;
      diff  = {bound[31], bound} - {org[31], org};
      dmag  = diff[32] ? (~diff + 33'd1) : diff;
      num   = {dmag, {FRAC_BITS{1'b0}}};
      high  = num[NUM_W-1:QW];
      r.rem = {{(32 - FRAC_BITS){1'b0}}, high};
      r.low = num[QW-1:0];
      r.quo = '0;
      r.dvs = mag32(dir);
      r.neg = diff[32] ^ dir[31];
      // quotient at least 2^QW: saturate without dividing
      r.ovf = (r.rem >= r.dvs);
      return r;
   endfunction

   function automatic lane_type lane_step(input lane_type x);
      logic [32:0] t;
      lane_type    r;
      r = x;
      t = {x.rem, x.low[QW-1]};
      if (t >= {1'b0, x.dvs}) begin
         t     = t - {1'b0, x.dvs};
         r.quo = {x.quo[QW-2:0], 1'b1};
      end else begin
         r.quo = {x.quo[QW-2:0], 1'b0};
      end
      r.rem = t[31:0];
      r.low = {x.low[QW-2:0], 1'b0};
      return r;
   endfunction

   function automatic cls_type cls_step(input cls_type x);
      cls_type r;
      r = x;
      for (int i = 0; i < LANES; i++) begin
         r.lane[i] = lane_step(x.lane[i]);
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_q(input lane_type x);
      logic [31:0] r;
      if (x.neg) begin
         if (x.ovf || x.quo > NEG_LIM) r = INT_MIN;
         else                          r = ~x.quo[31:0] + 32'd1;
      end else begin
         if (x.ovf || x.quo[QW-1:31] != '0) r = INT_MAX;
         else                                r = x.quo[31:0];
      end
      return r;
   endfunction

endpackage

@@ sv/ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box slab test, signed Q16.16, streaming.
// ---------------------------------------------------------------------------
// Input: push req_data (box corners, origin, direction) while req_full is
// low; each such edge moves one transaction. Results: while rsp_empty is low
// rsp_data holds the oldest result (hit, entry_distance); pulse rsp_pop to
// take it. Each request yields exactly one result, in order.
// csr_we/csr_wdata write the 16-bit zero epsilon; write it only while idle.
// Throughput: one transaction per cycle, sustained while the receiver keeps
// up. Path of a result: front register, classified-item queue, divider input
// register, 33 divider stages (one quotient bit per stage in each of six
// lanes), saturate, order, reduce and the result queue.
// The 33-stage divider pipeline makes up most of the latency.
// When the receiver stalls, the pipeline freezes once the result queue is
// full; the classified-item queue then fills and req_full rises.
// Reset (synchronous, active high) empties every queue and the pipeline and
// sets the epsilon to 1.
// ---------------------------------------------------------------------------
module ray_box_slab_intersect (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire rbs_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rbs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [15:0]      csr_wdata
);

   logic             cls_push, cls_full, cls_pop, cls_empty;
   rbs_pkg::cls_type cls_in_data, cls_out_data;

   rbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cls_push  (cls_push),
      .cls_data  (cls_in_data),
      .cls_full  (cls_full)
   );

   rbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cls_push),
      .push_data (cls_in_data),
      .full      (cls_full),
      .pop       (cls_pop),
      .pop_data  (cls_out_data),
      .empty     (cls_empty)
   );

   rbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_pop   (cls_pop),
      .cls_data  (cls_out_data),
      .cls_empty (cls_empty),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.hit) |-> (rsp_data.entry_distance == 32'sd0))
      else $error("miss result carries a nonzero distance");

   a_empty_by_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> ($past(rsp_pop) || $past(reset)))
      else $error("result dropped without a pop");
`endif

endmodule
`default_nettype wire

@@ sv/rbs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_front
// Accepts transactions, holds the epsilon register and classifies each axis
// (parallel or not) and sets up the six divider lanes.
// ---------------------------------------------------------------------------
module rbs_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire rbs_pkg::req_type req_data,
   input  wire logic            csr_we,
   input  wire logic [15:0]     csr_wdata,
   output logic                 cls_push,
   output rbs_pkg::cls_type     cls_data,
   input  wire logic            cls_full
);

   logic [15:0]      eps_ff, eps_in;
   logic             vld_ff, vld_in;
   rbs_pkg::cls_type cls_ff, cls_in;
   logic             accept;

   logic [rbs_pkg::AXES-1:0][31:0] lo, hi, org, dir;

   assign req_full = vld_ff & cls_full;
   assign accept   = req_push & ~req_full;
   assign cls_push = vld_ff & ~cls_full;
   assign cls_data = cls_ff;

   assign eps_in = csr_we ? csr_wdata : eps_ff;
   assign vld_in = accept | (vld_ff & cls_full);

   always_comb begin
      lo  = {req_data.box_min_z, req_data.box_min_y, req_data.box_min_x};
      hi  = {req_data.box_max_z, req_data.box_max_y, req_data.box_max_x};
      org = {req_data.origin_z, req_data.origin_y, req_data.origin_x};
      dir = {req_data.dir_z, req_data.dir_y, req_data.dir_x};
      cls_in.pmiss = 1'b0;
      for (int a = 0; a < rbs_pkg::AXES; a++) begin
         cls_in.lane[2*a]     = rbs_pkg::lane_prep(lo[a], org[a], dir[a]);
         cls_in.lane[2*a + 1] = rbs_pkg::lane_prep(hi[a], org[a], dir[a]);
         cls_in.par[a] = (rbs_pkg::mag32(dir[a]) <= {16'd0, eps_ff});
         if (cls_in.par[a] &&
             (($signed(org[a]) < $signed(lo[a])) || ($signed(org[a]) > $signed(hi[a]))))
         begin
            cls_in.pmiss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= rbs_pkg::EPS_RST;
         vld_ff <= 1'b0;
      end else begin
         eps_ff <= eps_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cls_ff <= cls_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/rbs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_queue
// Short queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module rbs_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rbs_pkg::cls_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output rbs_pkg::cls_type      pop_data,
   output logic                  empty
);

   rbs_pkg::cls_type mem_ff [rbs_pkg::QDEPTH];
   logic [rbs_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rbs_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                       do_push, do_pop;

   assign full     = (cnt_ff == rbs_pkg::QCNT_W'(rbs_pkg::QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ff];

   assign wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + rbs_pkg::QCNT_W'(do_push) - rbs_pkg::QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ sv/rbs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_back
// Six pipelined restoring dividers (one quotient bit per stage), then
// saturation, slab ordering, reduction and the hit decision into a
// two-entry result queue.
// ---------------------------------------------------------------------------
module rbs_back (
   input  wire logic             clock,
   input  wire logic             reset,
   output logic                  cls_pop,
   input  wire rbs_pkg::cls_type cls_data,
   input  wire logic             cls_empty,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rbs_pkg::rsp_type      rsp_data
);

   localparam int QW = rbs_pkg::QW;
   localparam int AX = rbs_pkg::AXES;

   rbs_pkg::cls_type div_ff [QW+1];
   logic [QW:0]      vld_ff, vld_in;

   logic [rbs_pkg::LANES-1:0][31:0] sat_ff, sat_in;
   logic [AX-1:0]                   spar_ff;
   logic                            spmiss_ff, svld_ff;

   logic [AX-1:0][31:0] near_ff, near_in, far_ff, far_in;
   logic [AX-1:0]       wpar_ff;
   logic                wpmiss_ff, wvld_ff;

   logic [31:0] entry_ff, entry_in, exit_ff, exit_in;
   logic        any_ff, any_in, rpmiss_ff, rvld_ff;

   rbs_pkg::rsp_type out_ff [2];
   logic             owr_ff, owr_in, ord_ff, ord_in;
   logic [1:0]       ocnt_ff, ocnt_in;
   logic             ofull, opush, opop, adv, hit;

   assign ofull   = (ocnt_ff == 2'd2);
   assign adv     = ~rvld_ff | ~ofull;
   assign cls_pop = adv & ~cls_empty;
   assign opush   = adv & rvld_ff;
   assign opop    = rsp_pop & ~rsp_empty;

   assign vld_in = {vld_ff[QW-1:0], ~cls_empty};

   always_comb begin
      for (int i = 0; i < rbs_pkg::LANES; i++) begin
         sat_in[i] = rbs_pkg::sat_q(div_ff[QW].lane[i]);
      end
   end

   // order each slab's two parameters
   always_comb begin
      for (int a = 0; a < AX; a++) begin
         if ($signed(sat_ff[2*a]) > $signed(sat_ff[2*a + 1])) begin
            near_in[a] = sat_ff[2*a + 1];
            far_in[a]  = sat_ff[2*a];
         end else begin
            near_in[a] = sat_ff[2*a];
            far_in[a]  = sat_ff[2*a + 1];
         end
      end
   end

   // largest entry and smallest exit over the non-parallel axes
   always_comb begin
      entry_in = rbs_pkg::INT_MIN;
      exit_in  = rbs_pkg::INT_MAX;
      any_in   = 1'b0;
      for (int a = 0; a < AX; a++) begin
         if (!wpar_ff[a]) begin
            any_in = 1'b1;
            if ($signed(near_ff[a]) > $signed(entry_in)) entry_in = near_ff[a];
            if ($signed(far_ff[a]) < $signed(exit_in))   exit_in  = far_ff[a];
         end
      end
   end

   assign hit = ~rpmiss_ff &
                ~(any_ff & (exit_ff[31] | ($signed(entry_ff) > $signed(exit_ff))));

   assign owr_in  = opush ? ~owr_ff : owr_ff;
   assign ord_in  = opop ? ~ord_ff : ord_ff;
   assign ocnt_in = ocnt_ff + 2'(opush) - 2'(opop);

   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_data  = out_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         svld_ff <= 1'b0;
         wvld_ff <= 1'b0;
         rvld_ff <= 1'b0;
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         if (adv) begin
            vld_ff  <= vld_in;
            svld_ff <= vld_ff[QW];
            wvld_ff <= svld_ff;
            rvld_ff <= wvld_ff;
         end
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= cls_data;
         for (int s = 1; s <= QW; s++) begin
            div_ff[s] <= rbs_pkg::cls_step(div_ff[s-1]);
         end
         sat_ff    <= sat_in;
         spar_ff   <= div_ff[QW].par;
         spmiss_ff <= div_ff[QW].pmiss;
         near_ff   <= near_in;
         far_ff    <= far_in;
         wpar_ff   <= spar_ff;
         wpmiss_ff <= spmiss_ff;
         entry_ff  <= entry_in;
         exit_ff   <= exit_in;
         any_ff    <= any_in;
         rpmiss_ff <= wpmiss_ff;
      end
      if (opush) begin
         out_ff[owr_ff].hit            <= hit;
         out_ff[owr_ff].entry_distance <= hit ? entry_ff : 32'd0;
      end
   end

endmodule
`default_nettype wire

@@ bench/ray_box_slab_intersect_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_test
// Streams ray/box slab tests through the block under varying epsilon and
// idling, predicts each result and checks it field by field, in order.
// ---------------------------------------------------------------------------
module ray_box_slab_intersect_test;

   localparam int LATENCY   = 40;
   localparam int WDOG_MAX  = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   rbs_pkg::req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rbs_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   ray_box_slab_intersect i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   rbs_pkg::req_type ray_pending[$];
   rbs_pkg::rsp_type hit_expected[$];
   logic [15:0] eps_model = 16'd1;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  recv_hold = 1'b0;
   int  errors = 0;
   int  quiet_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // (bound - org) * 2^16 / dir, truncated toward zero, saturated to 32 bits
   function automatic longint slab_quotient(logic signed [31:0] bound,
                                            logic signed [31:0] org,
                                            logic signed [31:0] dir);
      longint num;
      longint q;
      num = (longint'(bound) - longint'(org)) * 65536;
      q = num / longint'(dir);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
   endfunction

   function automatic rbs_pkg::rsp_type slab_test(rbs_pkg::req_type r, logic [15:0] eps);
      logic signed [31:0] lo[3], hi[3], org[3], dir[3];
      longint entry, exit_t, s, t, mag;
      bit miss, any_slab;
      rbs_pkg::rsp_type o;
      lo  = '{r.box_min_x, r.box_min_y, r.box_min_z};
      hi  = '{r.box_max_x, r.box_max_y, r.box_max_z};
      org = '{r.origin_x, r.origin_y, r.origin_z};
      dir = '{r.dir_x, r.dir_y, r.dir_z};
      entry = -64'sd2147483648;
      exit_t = 64'sd2147483647;
      miss = 0;
      any_slab = 0;
      for (int a = 0; a < 3; a++) begin
         mag = longint'(dir[a]);
         if (mag < 0) mag = -mag;
         if (mag <= longint'(eps)) begin
            if (org[a] < lo[a] || org[a] > hi[a]) miss = 1;
         end else begin
            s = slab_quotient(lo[a], org[a], dir[a]);
            t = slab_quotient(hi[a], org[a], dir[a]);
            if (s > t) begin
               mag = s; s = t; t = mag;
            end
            if (s > entry) entry = s;
            if (t < exit_t) exit_t = t;
            any_slab = 1;
         end
      end
      if (any_slab && (exit_t < 0 || entry > exit_t)) miss = 1;
      o.hit = !miss;
      o.entry_distance = miss ? 32'sd0 : 32'(entry);
      return o;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      endcase
   endfunction

   // mostly well-formed boxes around small rays, some raw noise
   function automatic rbs_pkg::req_type rand_ray();
      rbs_pkg::req_type r;
      logic signed [31:0] a, b;
      logic [31:0] v[12];
      if ($urandom_range(0, 9) == 0) begin
         foreach (v[i]) v[i] = rand_word();
         r = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         a = rand_word();
         b = rand_word();
         if ($urandom_range(0, 9) != 0 && a > b) begin
            v[i] = b; v[3 + i] = a;
         end else begin
            v[i] = a; v[3 + i] = b;
         end
         v[6 + i] = rand_word();
         case ($urandom_range(0, 4))
            0: v[9 + i] = 32'($signed($urandom_range(0, 4)) - 2);
            1: v[9 + i] = rand_word();
            default: v[9 + i] = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
         endcase
      end
      r = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
      return r;
   endfunction

   // driver: one transaction per accepting edge, random idle cycles
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            hit_expected.push_back(slab_test(req_data, eps_model));
            void'(ray_pending.pop_front());
         end
         if ((!req_push || !req_full || ray_pending.size() == 0)) begin
            if ((req_push && !req_full ? ray_pending.size() > 0 : ray_pending.size() > 0)
                && $urandom_range(0, 99) >= send_idle_pct) begin
               req_push <= 1'b1;
               req_data <= ray_pending[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each popped result with the oldest prediction
   always @(posedge clock) begin
      rbs_pkg::rsp_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (hit_expected.size() == 0) begin
               $error("unexpected result hit=%0b entry_distance=%0d",
                      rsp_data.hit, rsp_data.entry_distance);
               errors++;
            end else begin
               e = hit_expected.pop_front();
               if (rsp_data.hit !== e.hit) begin
                  $error("hit: expected %0b actual %0b", e.hit, rsp_data.hit);
                  errors++;
               end
               if (rsp_data.entry_distance !== e.entry_distance) begin
                  $error("entry_distance: expected %0d actual %0d",
                         e.entry_distance, rsp_data.entry_distance);
                  errors++;
               end
            end
         end
         rsp_pop <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic drain();
      while (ray_pending.size() != 0 || req_push) @(posedge clock);
      while (hit_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_epsilon(logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      eps_model = v;
   endtask

   task automatic add_ray(logic [31:0] v[12]);
      ray_pending.push_back({v[0], v[1], v[2], v[3], v[4], v[5],
                             v[6], v[7], v[8], v[9], v[10], v[11]});
   endtask

   initial begin
      logic [31:0] v[12];
      int unsigned hold_len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unit box, axis rays, parallel cases, extremes
      v = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
            32'h0001_0000, 32'hFFFB_0000, 0, 0, 32'h0001_0000, 0, 0};
      add_ray(v);                                   // hit along x
      v[9] = 32'hFFFF_0000; add_ray(v);             // pointing away
      v[6] = 0; add_ray(v);                          // origin inside box
      v[9] = 0; add_ray(v);                          // all parallel, inside
      v[7] = 32'h0001_0000; add_ray(v);              // parallel, on bound
      v[7] = 32'h0001_0001; add_ray(v);              // parallel, just outside
      v[7] = 0; v[9] = 1; add_ray(v);                // magnitude at epsilon
      v[9] = 2; add_ray(v);                          // just above epsilon
      v[9] = 32'hFFFF_FFFF; add_ray(v);
      v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 2, 32'hFFFF_FFFE, 32'h8000_0000};
      add_ray(v);                                    // saturating quotients
      v[11] = 32'h7FFF_FFFF; add_ray(v);
      v = '{32'h0001_0000, 0, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0, 0};
      add_ray(v);                                    // inverted box, parallel
      v[9] = 32'h0001_0000; add_ray(v);              // inverted box, crossing
      v = '{0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'hFFFF_0000,
            32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
      add_ray(v);                                    // diagonal hit
      v[10] = 32'h0000_4000; add_ray(v);             // slabs disjoint
      drain();

      set_epsilon(16'd0);
      v = '{0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1, 0, 0};
      add_ray(v); v[9] = 0; add_ray(v);
      drain();
      set_epsilon(16'hFFFF);
      v[9] = 32'h0000_FFFF; add_ray(v); v[9] = 32'hFFFF_0001; add_ray(v);
      v[9] = 32'h0001_0000; add_ray(v);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            3: begin send_idle_pct = 36; recv_stall_pct = 36; end
            4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         set_epsilon(ph == 4 ? 16'hFFFF : (ph == 0 ? 16'd1 : 16'($urandom_range(0, 65535))));
         for (int i = 0; i < 108; i++) ray_pending.push_back(rand_ray());
         if (ph == 4) begin
            // long receiver hold-off so the block fills and asserts full
            recv_hold = 1'b1;
            hold_len = 200;
            repeat (hold_len) @(posedge clock);
            recv_hold = 1'b0;
         end
         drain();
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/rbs_pkg.sv
sv/rbs_front.sv
sv/rbs_queue.sv
sv/rbs_back.sv
sv/ray_box_slab_intersect.sv
bench/ray_box_slab_intersect_test.sv
